// ===== rtl/hfr_pkg.sv =====
// hfr_pkg: shared types, constants and matcher functions for the request framer
// used by every module of http_request_framer and by its checker
// no dependencies
`timescale 1ns / 1ps

package hfr_pkg;

    localparam int LENGTH_BITS = 31;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_FIELD_W = 8 + LENGTH_BITS;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_TUSER_W = 4;

    // m_axis_tuser bit positions
    localparam int TU_IN_BODY     = 0;
    localparam int TU_HEADER_LAST = 1;
    localparam int TU_MULTIPART   = 2;
    localparam int TU_FAILED      = 3;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int LEN_KEY_LEN  = 15;
    localparam int TYPE_KEY_LEN = 13;
    localparam int FORM_LEN     = 19;
    // after "multipart/form" a mismatch falls back to the lone leading 'm'
    localparam int FORM_REPEAT_AT = 14;

    localparam logic [LEN_KEY_LEN*8-1:0]  LEN_KEY_STR  = "Content-Length:";
    localparam logic [TYPE_KEY_LEN*8-1:0] TYPE_KEY_STR = "Content-Type:";
    localparam logic [FORM_LEN*8-1:0]     FORM_STR     = "multipart/form-data";

    localparam logic [3:0] LEN_KEY_DONE  = 4'(LEN_KEY_LEN);
    localparam logic [3:0] TYPE_KEY_DONE = 4'(TYPE_KEY_LEN);
    localparam logic [4:0] FORM_DONE     = 5'(FORM_LEN);

    typedef enum logic [1:0] {
        PH_HEADER = 2'b01,
        PH_BODY   = 2'b10
    } hfr_phase_t;

    typedef enum logic [3:0] {
        LV_NOT_FOUND = 4'b0001,
        LV_SKIP      = 4'b0010,
        LV_DIGITS    = 4'b0100,
        LV_DONE      = 4'b1000
    } hfr_len_mode_t;

    typedef enum logic [3:0] {
        TV_SEARCH = 4'b0001,
        TV_SKIP   = 4'b0010,
        TV_VALUE  = 4'b0100,
        TV_DONE   = 4'b1000
    } hfr_type_mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       closed;
    } hfr_item_t;

    typedef struct packed {
        logic [7:0]             byte_out;
        logic                   in_body;
        logic                   header_last;
        logic                   request_last;
        logic [LENGTH_BITS-1:0] body_length;
        logic                   multipart;
        logic                   failed;
    } hfr_result_t;

    function automatic logic [7:0] len_key_char(input logic [3:0] idx);
        return LEN_KEY_STR[8*(LEN_KEY_LEN-1-int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] type_key_char(input logic [3:0] idx);
        return TYPE_KEY_STR[8*(TYPE_KEY_LEN-1-int'(idx)) +: 8];
    endfunction

    function automatic logic [7:0] form_char(input logic [4:0] idx);
        return FORM_STR[8*(FORM_LEN-1-int'(idx)) +: 8];
    endfunction

    function automatic logic [3:0] len_key_step(input logic [3:0] idx, input logic [7:0] c);
        logic [3:0] nxt;
        if (c == len_key_char(idx))
            nxt = idx + 4'd1;
        else if (c == len_key_char(4'd0))
            nxt = 4'd1;
        else
            nxt = 4'd0;
        return nxt;
    endfunction

    function automatic logic [3:0] type_key_step(input logic [3:0] idx, input logic [7:0] c);
        logic [3:0] nxt;
        if (c == type_key_char(idx))
            nxt = idx + 4'd1;
        else if (c == type_key_char(4'd0))
            nxt = 4'd1;
        else
            nxt = 4'd0;
        return nxt;
    endfunction

    function automatic logic [4:0] form_step(input logic [4:0] idx, input logic [7:0] c);
        logic [4:0] nxt;
        if (c == form_char(idx))
            nxt = idx + 5'd1;
        else if (idx == 5'(FORM_REPEAT_AT) && c == form_char(5'd1))
            nxt = 5'd2;
        else if (c == form_char(5'd0))
            nxt = 5'd1;
        else
            nxt = 5'd0;
        return nxt;
    endfunction

endpackage

// ===== rtl/hfr_in_stage.sv =====
// hfr_in_stage: input register of the request framer
// holds one accepted item until the parser takes it; uses hfr_pkg
`timescale 1ns / 1ps

module hfr_in_stage
    import hfr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_TDATA_W-1:0] s_axis_tdata,   // data_byte
    input  logic [0:0]            s_axis_tuser,   // closed
    input  logic                  take,
    output logic                  item_valid,
    output hfr_item_t             item
);

    logic      valid_reg;
    hfr_item_t item_reg;

    assign s_axis_tready = !valid_reg || take;
    assign item_valid    = valid_reg;
    assign item          = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            item_reg.data_byte <= s_axis_tdata[7:0];
            item_reg.closed    <= s_axis_tuser[0];
        end
    end

endmodule

// ===== rtl/hfr_parse.sv =====
// hfr_parse: header matchers, length parser and body counter of the request framer
// one item per cycle while out_ready; state advances on take; uses hfr_pkg
`timescale 1ns / 1ps

module hfr_parse
    import hfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  hfr_item_t   item,
    input  logic        out_ready,
    output logic        take,
    output hfr_result_t result
);

    hfr_phase_t             phase_reg,      phase_next;
    logic [1:0]             blank_reg,      blank_next;
    logic [3:0]             len_key_reg,    len_key_next;
    hfr_len_mode_t          len_mode_reg,   len_mode_next;
    logic [LENGTH_BITS-1:0] accum_reg,      accum_next;
    logic [3:0]             type_key_reg,   type_key_next;
    hfr_type_mode_t         type_mode_reg,  type_mode_next;
    logic [4:0]             form_reg,       form_next;
    logic                   mp_reg,         mp_next;
    logic [LENGTH_BITS-1:0] remain_reg,     remain_next;

    logic [7:0]             c;
    logic                   is_ws;
    logic                   is_digit;
    logic                   prev_cr;
    logic                   blank_done;
    logic                   value_go;
    logic [3:0]             key_step;
    logic [3:0]             tkey_step;
    logic [4:0]             fstep;
    logic [LENGTH_BITS+3:0] accum_x10;
    logic [LENGTH_BITS+3:0] accum_sum;
    logic [LENGTH_BITS-1:0] remain_dec;
    logic                   req_last;

    assign take = item_valid && out_ready;
    assign c    = item.data_byte;

    always_comb
    begin
        is_ws      = c inside {CH_SPACE, CH_TAB};
        is_digit   = c inside {[CH_ZERO:CH_NINE]};
        prev_cr    = blank_reg[0];
        key_step   = len_key_step(len_key_reg, c);
        tkey_step  = type_key_step(type_key_reg, c);
        fstep      = form_step(form_reg, c);
        accum_x10  = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0};
        accum_sum  = accum_x10 + {{LENGTH_BITS{1'b0}}, c[3:0]};
        remain_dec = remain_reg - LENGTH_BITS'(1);
        blank_done = 1'b0;
        value_go   = 1'b0;
        req_last   = 1'b0;

        phase_next     = phase_reg;
        blank_next     = blank_reg;
        len_key_next   = len_key_reg;
        len_mode_next  = len_mode_reg;
        accum_next     = accum_reg;
        type_key_next  = type_key_reg;
        type_mode_next = type_mode_reg;
        form_next      = form_reg;
        mp_next        = mp_reg;
        remain_next    = remain_reg;

        result.byte_out     = c;
        result.in_body      = 1'b0;
        result.header_last  = 1'b0;
        result.request_last = 1'b0;
        result.body_length  = '0;
        result.multipart    = 1'b0;
        result.failed       = 1'b0;

        if (item.closed)
        begin
            result.byte_out = '0;
            result.failed   = 1'b1;
        end
        else if (phase_reg == PH_BODY)
        begin
            remain_next = remain_dec;
            req_last    = (remain_dec == '0);
            result.in_body = 1'b1;
        end
        else
        begin
            // blank line matcher: CR LF CR LF
            case (blank_reg)
                2'd1:    blank_next = (c == CH_LF) ? 2'd2 : ((c == CH_CR) ? 2'd1 : 2'd0);
                2'd2:    blank_next = (c == CH_CR) ? 2'd3 : 2'd0;
                2'd3:
                begin
                    blank_done = (c == CH_LF);
                    blank_next = (c == CH_CR) ? 2'd1 : 2'd0;
                end
                default: blank_next = (c == CH_CR) ? 2'd1 : 2'd0;
            endcase

            case (len_mode_reg)
                LV_NOT_FOUND:
                begin
                    if (key_step == LEN_KEY_DONE)
                    begin
                        len_key_next  = 4'd0;
                        len_mode_next = LV_SKIP;
                    end
                    else
                    begin
                        len_key_next = key_step;
                    end
                end
                LV_SKIP:
                begin
                    if (is_digit)
                    begin
                        accum_next    = {{(LENGTH_BITS-4){1'b0}}, c[3:0]};
                        len_mode_next = LV_DIGITS;
                    end
                    else if (!is_ws)
                    begin
                        accum_next    = '0;
                        len_mode_next = LV_DONE;
                    end
                end
                LV_DIGITS:
                begin
                    if (!is_digit)
                    begin
                        len_mode_next = LV_DONE;
                    end
                    else if (|accum_sum[LENGTH_BITS+3:LENGTH_BITS])
                    begin
                        accum_next    = '0;
                        len_mode_next = LV_DONE;
                    end
                    else
                    begin
                        accum_next = accum_sum[LENGTH_BITS-1:0];
                    end
                end
                default: ;
            endcase

            case (type_mode_reg)
                TV_SEARCH:
                begin
                    if (tkey_step == TYPE_KEY_DONE)
                    begin
                        type_key_next  = 4'd0;
                        type_mode_next = TV_SKIP;
                    end
                    else
                    begin
                        type_key_next = tkey_step;
                    end
                end
                TV_SKIP:  value_go = !is_ws;
                TV_VALUE: value_go = 1'b1;
                default:  ;
            endcase

            if (value_go)
            begin
                type_mode_next = TV_VALUE;
                if (c == CH_LF && prev_cr)
                begin
                    type_mode_next = TV_DONE;
                end
                else if (fstep == FORM_DONE)
                begin
                    mp_next        = 1'b1;
                    form_next      = 5'd0;
                    type_mode_next = TV_DONE;
                end
                else
                begin
                    form_next = fstep;
                end
            end

            if (blank_done)
            begin
                result.header_last = 1'b1;
                if (accum_next == '0)
                begin
                    req_last = 1'b1;
                end
                else
                begin
                    phase_next  = PH_BODY;
                    remain_next = accum_next;
                end
            end

            result.body_length = accum_next;
            result.multipart   = mp_next;
        end

        if (!item.closed && phase_reg == PH_BODY)
        begin
            result.body_length = accum_reg;
            result.multipart   = mp_reg;
        end
        result.request_last = req_last;

        // close or end of request: back to the reset state
        if (item.closed || req_last)
        begin
            phase_next     = PH_HEADER;
            blank_next     = 2'd0;
            len_key_next   = 4'd0;
            len_mode_next  = LV_NOT_FOUND;
            accum_next     = '0;
            type_key_next  = 4'd0;
            type_mode_next = TV_SEARCH;
            form_next      = 5'd0;
            mp_next        = 1'b0;
            remain_next    = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            blank_reg     <= 2'd0;
            len_key_reg   <= 4'd0;
            len_mode_reg  <= LV_NOT_FOUND;
            accum_reg     <= '0;
            type_key_reg  <= 4'd0;
            type_mode_reg <= TV_SEARCH;
            form_reg      <= 5'd0;
            mp_reg        <= 1'b0;
            remain_reg    <= '0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            blank_reg     <= blank_next;
            len_key_reg   <= len_key_next;
            len_mode_reg  <= len_mode_next;
            accum_reg     <= accum_next;
            type_key_reg  <= type_key_next;
            type_mode_reg <= type_mode_next;
            form_reg      <= form_next;
            mp_reg        <= mp_next;
            remain_reg    <= remain_next;
        end
    end

endmodule

// ===== rtl/hfr_out_stage.sv =====
// hfr_out_stage: result register with skid entry for the request framer
// packs results onto the master stream; uses hfr_pkg
`timescale 1ns / 1ps

module hfr_out_stage
    import hfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  hfr_result_t            result,
    output logic                   ready,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,
    output logic                   m_axis_tlast
);

    logic        out_valid_reg;
    logic        skid_valid_reg;
    hfr_result_t out_reg;
    hfr_result_t skid_reg;
    logic        advance;

    assign ready   = !skid_valid_reg;
    assign advance = m_axis_tready || !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg  <= skid_valid_reg || push;
            skid_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= skid_valid_reg ? skid_reg : result;
        end
        else if (push)
        begin
            skid_reg <= result;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-OUT_FIELD_W){1'b0}}, out_reg.body_length,
                            out_reg.byte_out};
    assign m_axis_tuser  = {out_reg.failed, out_reg.multipart, out_reg.header_last,
                            out_reg.in_body};
    assign m_axis_tlast  = out_reg.request_last;

endmodule

// ===== rtl/http_request_framer.sv =====
// http_request_framer: top level of the HTTP/1 request framer
// instantiates hfr_in_stage, hfr_parse and hfr_out_stage; uses hfr_pkg
//
// Takes one byte of a request stream per item and returns one result item per
// input item, one item per clock cycle sustained while the master side accepts
// results. Each item passes an input register, the matcher, length and
// body-count logic, and a result register; a skid entry behind the result
// register holds one result, so input is still taken when downstream first stalls.
// Until CR LF CR LF the block reads Content-Length (first occurrence, decimal
// prefix, 0 if absent, negative or too large) and flags multipart/form-data in
// the first Content-Type value, then counts body bytes and marks the last byte
// of each request with tlast. An item with the closed flag returns a failed
// result with all other fields zero and restarts parsing.
`timescale 1ns / 1ps

module http_request_framer
    import hfr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // data_byte
    input  logic [0:0]             s_axis_tuser,   // closed
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // byte_out, body_length, zero pad
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // in_body, header_last, multipart, failed
    output logic                   m_axis_tlast    // request_last
);

    logic        item_valid;
    hfr_item_t   item;
    logic        take;
    logic        out_ready;
    hfr_result_t result;

    hfr_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .take          (take),
        .item_valid    (item_valid),
        .item          (item)
    );

    hfr_parse u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .out_ready  (out_ready),
        .take       (take),
        .result     (result)
    );

    hfr_out_stage u_out_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (take),
        .result        (result),
        .ready         (out_ready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// ===== rtl/hfr_checker.sv =====
// hfr_checker: port-level assertions for http_request_framer
// bound to the top level below; uses hfr_pkg
`timescale 1ns / 1ps

module hfr_checker
    import hfr_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [OUT_TUSER_W-1:0] m_axis_tuser,
    input logic                   m_axis_tlast
);

    logic [LENGTH_BITS-1:0] out_length;
    assign out_length = m_axis_tdata[OUT_FIELD_W-1:8];

    // a failed item carries nothing else
    a_failed_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[TU_FAILED] |->
            m_axis_tdata == '0 && !m_axis_tlast && !m_axis_tuser[TU_IN_BODY]
            && !m_axis_tuser[TU_HEADER_LAST] && !m_axis_tuser[TU_MULTIPART])
        else $error("failed item with nonzero fields");

    // header end ends the request exactly when the length is zero
    a_header_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[TU_HEADER_LAST] |->
            !m_axis_tuser[TU_IN_BODY] && (m_axis_tlast == (out_length == '0)))
        else $error("header end and request end disagree");

    // a body item never follows a completed request directly
    a_body_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && m_axis_tlast ##1
            (m_axis_tvalid && !m_axis_tuser[TU_FAILED]) |->
            !m_axis_tuser[TU_IN_BODY] || !$past(m_axis_tvalid && m_axis_tready))
        else $error("body item right after request end");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result changed while stalled");

endmodule

bind http_request_framer hfr_checker u_hfr_checker (.*);
